// ===== hdl/kcl_pkg.sv =====
package kcl_pkg;

	localparam int CODE_LEN = 4;
	localparam int IDX_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
	localparam int CNT_W = $clog2(CODE_LEN + 1);
	localparam int MS_W = 18;
	localparam logic [MS_W-1:0] ELAPSED_MAX = '1;

	// floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every 18-bit x
	localparam int RECIP_SHIFT = 28;
	localparam logic [18:0] RECIP_1000 = 19'd268436;
	localparam int PROD_W = MS_W + 19;

	localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd0;
	localparam logic [1:0] REG_NORMAL_LOCK = 2'd1;
	localparam logic [1:0] REG_CHANGE_LOCK = 2'd2;

	typedef enum logic [2:0] {
		MODE_TICK       = 3'd0,
		MODE_DIGIT      = 3'd1,
		MODE_VERIFY     = 3'd2,
		MODE_CLEAR      = 3'd3,
		MODE_BEGIN_CHG  = 3'd4,
		MODE_CHG_DIGIT  = 3'd5,
		MODE_CANCEL_CHG = 3'd6,
		MODE_LOAD       = 3'd7
	} kcl_mode_t;

	typedef enum logic [1:0] {
		CHG_CONTINUE = 2'd0,
		CHG_DONE     = 2'd1,
		CHG_LOCKED   = 2'd2,
		CHG_RETRY    = 2'd3
	} kcl_chg_t;

	typedef logic [CODE_LEN-1:0][7:0] kcl_code_t;

	typedef struct packed {
		logic [3:0]      max_attempts;
		logic [MS_W-1:0] normal_lock_ms;
		logic [MS_W-1:0] change_lock_ms;
	} kcl_cfg_t;

	typedef struct packed {
		kcl_mode_t   mode;
		logic [7:0]  digit;
		logic [31:0] code_word;
	} kcl_item_t;

	typedef struct packed {
		logic            entry_full;
		logic            code_ok;
		kcl_chg_t        change_status;
		logic            lock_released;
		logic            is_locked;
		logic [MS_W-1:0] remaining_ms;
		logic [2:0]      digits_entered;
		logic [3:0]      failures;
		logic            change_phase;
		logic            save_strobe;
		logic [31:0]     saved_code;
	} kcl_res_t;

endpackage

// ===== hdl/kcl_in_if.sv =====
interface kcl_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [7:0]  digit;
	logic [31:0] code_word;

	modport source(output valid, mode, digit, code_word, input ready);
	modport sink(input valid, mode, digit, code_word, output ready);
endinterface

// ===== hdl/kcl_out_if.sv =====
interface kcl_out_if;
	logic        valid;
	logic        ready;
	logic        entry_full;
	logic        code_ok;
	logic [1:0]  change_status;
	logic        lock_released;
	logic        is_locked;
	logic [7:0]  seconds_left;
	logic [2:0]  digits_entered;
	logic [3:0]  failures;
	logic        change_phase;
	logic        save_strobe;
	logic [31:0] saved_code;

	modport source(output valid, entry_full, code_ok, change_status, lock_released, is_locked,
		seconds_left, digits_entered, failures, change_phase, save_strobe, saved_code,
		input ready);
	modport sink(input valid, entry_full, code_ok, change_status, lock_released, is_locked,
		seconds_left, digits_entered, failures, change_phase, save_strobe, saved_code,
		output ready);
endinterface

// ===== hdl/kcl_cfg_if.sv =====
interface kcl_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [17:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/kcl_core.sv =====
module kcl_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  kcl_pkg::kcl_cfg_t  cfg,
	input  kcl_pkg::kcl_item_t item,
	output kcl_pkg::kcl_res_t  res
);
	import kcl_pkg::*;

	kcl_code_t       stored_q, entry_q, check_q, new_q;
	kcl_code_t       stored_n, entry_n, check_n, new_n;
	logic [CNT_W-1:0] dc_q, dc_n;
	logic [3:0]      fc_q, fc_n, cfc_q, cfc_n;
	logic            phase_q, phase_n;
	logic            nl_q, nl_n, cl_q, cl_n;
	logic [MS_W-1:0] el_q, el_n;

	always_comb begin
		logic [MS_W-1:0]  e;
		logic [MS_W-1:0]  lim;
		logic [3:0]       inc;
		logic [IDX_W-1:0] idx;
		kcl_code_t        w;

		stored_n = stored_q;
		entry_n  = entry_q;
		check_n  = check_q;
		new_n    = new_q;
		dc_n     = dc_q;
		fc_n     = fc_q;
		cfc_n    = cfc_q;
		phase_n  = phase_q;
		nl_n     = nl_q;
		cl_n     = cl_q;
		el_n     = el_q;
		e        = el_q;
		inc      = '0;
		idx      = dc_q[IDX_W-1:0];
		w        = '0;
		res      = '0;
		res.change_status = CHG_CONTINUE;

		unique case (item.mode)
			MODE_TICK: begin
				if (cl_q || nl_q) begin
					e = (el_q != ELAPSED_MAX) ? el_q + MS_W'(1) : el_q;
					if (cl_q) begin
						if (e >= cfg.change_lock_ms) begin
							cl_n  = 1'b0;
							cfc_n = '0;
							e     = '0;
							res.lock_released = 1'b1;
						end
					end else if (e >= cfg.normal_lock_ms) begin
						nl_n = 1'b0;
						e    = '0;
						res.lock_released = 1'b1;
					end
					el_n = e;
				end
			end
			MODE_DIGIT: begin
				if (dc_q < CNT_W'(CODE_LEN)) begin
					entry_n[idx] = item.digit;
					dc_n = dc_q + CNT_W'(1);
					res.entry_full = (dc_n == CNT_W'(CODE_LEN));
				end
			end
			MODE_VERIFY: begin
				if (entry_q == stored_q) begin
					res.code_ok = 1'b1;
					fc_n = '0;
				end else begin
					inc = (fc_q == 4'hF) ? fc_q : fc_q + 4'd1;
					if (inc >= cfg.max_attempts) begin
						nl_n = 1'b1;
						el_n = '0;
						fc_n = '0;
					end else begin
						fc_n = inc;
					end
				end
			end
			MODE_CLEAR: begin
				dc_n    = '0;
				entry_n = '0;
			end
			MODE_BEGIN_CHG, MODE_CANCEL_CHG: begin
				phase_n = 1'b0;
				dc_n    = '0;
				cfc_n   = '0;
				check_n = '0;
				new_n   = '0;
			end
			MODE_CHG_DIGIT: begin
				if (dc_q < CNT_W'(CODE_LEN)) begin
					dc_n = dc_q + CNT_W'(1);
					if (!phase_q) begin
						w = check_q;
						w[idx] = item.digit;
						check_n = w;
						if (dc_n == CNT_W'(CODE_LEN)) begin
							if (w == stored_q) begin
								phase_n = 1'b1;
								dc_n    = '0;
								cfc_n   = '0;
								new_n   = '0;
							end else begin
								inc = (cfc_q == 4'hF) ? cfc_q : cfc_q + 4'd1;
								cfc_n = inc;
								dc_n  = '0;
								if (inc >= cfg.max_attempts) begin
									cl_n = 1'b1;
									el_n = '0;
									res.change_status = CHG_LOCKED;
								end else begin
									check_n = '0;
									res.change_status = CHG_RETRY;
								end
							end
						end
					end else begin
						w = new_q;
						w[idx] = item.digit;
						new_n = w;
						if (dc_n == CNT_W'(CODE_LEN)) begin
							stored_n = w;
							res.save_strobe = 1'b1;
							res.change_status = CHG_DONE;
							phase_n = 1'b0;
							dc_n    = '0;
							cfc_n   = '0;
							check_n = '0;
							new_n   = '0;
						end
					end
				end
			end
			MODE_LOAD: begin
				for (int i = 0; i < CODE_LEN; i++) begin
					stored_n[i] = (i < 4) ? item.code_word[(3 - (i % 4)) * 8 +: 8] : 8'h00;
				end
			end
			default: ;
		endcase

		// status reflects the state after this transaction
		lim = cl_n ? cfg.change_lock_ms : cfg.normal_lock_ms;
		res.is_locked = cl_n || nl_n;
		res.remaining_ms = ((cl_n || nl_n) && (el_n < lim)) ? lim - el_n : '0;
		res.digits_entered = 3'(dc_n);
		res.failures = fc_n;
		res.change_phase = phase_n;
		for (int i = 0; i < 4; i++) begin
			if (i < CODE_LEN) begin
				res.saved_code[(3 - i) * 8 +: 8] = stored_n[i % CODE_LEN];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
			entry_q  <= '0;
			check_q  <= '0;
			new_q    <= '0;
			dc_q     <= '0;
			fc_q     <= '0;
			cfc_q    <= '0;
			phase_q  <= 1'b0;
			nl_q     <= 1'b0;
			cl_q     <= 1'b0;
			el_q     <= '0;
		end else if (step) begin
			stored_q <= stored_n;
			entry_q  <= entry_n;
			check_q  <= check_n;
			new_q    <= new_n;
			dc_q     <= dc_n;
			fc_q     <= fc_n;
			cfc_q    <= cfc_n;
			phase_q  <= phase_n;
			nl_q     <= nl_n;
			cl_q     <= cl_n;
			el_q     <= el_n;
		end
	end

endmodule

// ===== hdl/kcl_secs.sv =====
module kcl_secs (
	input  logic [kcl_pkg::MS_W-1:0] remaining_ms,
	output logic [7:0]               seconds
);
	import kcl_pkg::*;

	logic [PROD_W-1:0]             prod;
	logic [PROD_W-RECIP_SHIFT-1:0] quot;

	// divide by 1000 through the reciprocal, then saturate to one byte
	assign prod = PROD_W'(remaining_ms) * PROD_W'(RECIP_1000);
	assign quot = prod[PROD_W-1:RECIP_SHIFT];
	assign seconds = (quot > (PROD_W-RECIP_SHIFT)'(255)) ? 8'hFF : quot[7:0];

endmodule

// ===== hdl/keypad_code_lock_with_lockout_top.sv =====
// Keypad code lock with attempt counting and timed lockout.
//
// req carries one event per transaction: a millisecond tick, a keypad digit,
// verify, clear, the code-change commands, or a code load. rsp returns exactly
// one status transaction per event, in order. cfg writes max_attempts (index 0),
// normal_lock_ms (index 1) and change_lock_ms (index 2); cfg.ready is always
// high, and writes should be made only while no event is in flight.
//
// Events pass an input register, the state-update stage and the seconds stage
// (multiply by the reciprocal of 1000). rsp.valid rises once the event has passed
// the input register, the state-update register and the output register. One
// event is accepted per cycle while req.ready is high; each stage holds its
// contents while the stage after it is full and stalled, so up to three events
// wait when rsp.ready is low before req.ready drops.
//
// Reset clears the stored code, the entry, both failure counters, both lockout
// flags and the lockout timer, and loads the register defaults 3, 30000 and
// 60000. No response is pending after reset.
module keypad_code_lock_with_lockout_top (
	input  logic clk,
	input  logic arst_n,
	kcl_in_if.sink   req,
	kcl_out_if.source rsp,
	kcl_cfg_if.sink  cfg
);
	import kcl_pkg::*;

	kcl_cfg_t  cfg_q;
	kcl_item_t item_s1;
	logic      valid_s1;
	kcl_res_t  res_comb, res_s2;
	logic      valid_s2;
	logic      valid_q;
	logic [7:0] secs;
	logic      adv1, adv2, take;

	assign adv2 = valid_s2 && (!valid_q || rsp.ready);
	assign adv1 = valid_s1 && (!valid_s2 || adv2);
	assign take = req.valid && req.ready;
	assign req.ready = !valid_s1 || adv1;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_attempts   <= 4'd3;
			cfg_q.normal_lock_ms <= MS_W'(30000);
			cfg_q.change_lock_ms <= MS_W'(60000);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MAX_ATTEMPTS: cfg_q.max_attempts   <= cfg.data[3:0];
				REG_NORMAL_LOCK:  cfg_q.normal_lock_ms <= cfg.data;
				REG_CHANGE_LOCK:  cfg_q.change_lock_ms <= cfg.data;
				default: ;
			endcase
		end
	end

	// hold the transaction until the state stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.mode      <= kcl_mode_t'(req.mode);
			item_s1.digit     <= req.digit;
			item_s1.code_word <= req.code_word;
		end
	end

	kcl_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (adv1),
		.cfg   (cfg_q),
		.item  (item_s1),
		.res   (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || adv2) begin
			valid_s2 <= adv1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			res_s2 <= res_comb;
		end
	end

	kcl_secs u_secs (
		.remaining_ms(res_s2.remaining_ms),
		.seconds     (secs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || rsp.ready) begin
			valid_q <= adv2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			rsp.entry_full     <= res_s2.entry_full;
			rsp.code_ok        <= res_s2.code_ok;
			rsp.change_status  <= res_s2.change_status;
			rsp.lock_released  <= res_s2.lock_released;
			rsp.is_locked      <= res_s2.is_locked;
			rsp.seconds_left   <= secs;
			rsp.digits_entered <= res_s2.digits_entered;
			rsp.failures       <= res_s2.failures;
			rsp.change_phase   <= res_s2.change_phase;
			rsp.save_strobe    <= res_s2.save_strobe;
			rsp.saved_code     <= res_s2.saved_code;
		end
	end

	assign rsp.valid = valid_q;

endmodule
